FILE: rtl/ttl_kv_pkg.sv
// Package: beat types, operation codes and sequencer states of the TTL key/value table.
`timescale 1ns / 1ps
package ttl_kv_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned COUNT_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd31;
  localparam logic [VAL_W-1:0]   MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_LOOKUP  = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_CLEANUP = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [KEY_W-1:0]  key;
    logic signed [VAL_W-1:0]  value;
    logic        [DUR_W-1:0]  duration;
  } in_beat_t;

  typedef struct packed {
    logic                     hit;
    logic signed [VAL_W-1:0]  result_value;
    logic                     status;
    logic [COUNT_W-1:0]       removed_count;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/ttl_kv_mem.sv
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module ttl_kv_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 113,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ttl_kv_ctrl.sv
// Sequencer: clearing pass, entry scans, read-modify-write of entries and the tick counter.
`timescale 1ns / 1ps
module ttl_kv_ctrl #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned ENT_W     = 113
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ttl_kv_pkg::in_beat_t  in_beat_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output ttl_kv_pkg::out_beat_t res_beat_o,
  output logic                  mem_we_o,
  output logic [IDX_W-1:0]      mem_waddr_o,
  output logic [ENT_W-1:0]      mem_wdata_o,
  output logic                  mem_re_o,
  output logic [IDX_W-1:0]      mem_raddr_o,
  input  logic [ENT_W-1:0]      mem_rdata_i
);
  import ttl_kv_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  state_e                 state_q, state_d;
  in_beat_t               item_q, item_d;
  logic [TIME_BITS-1:0]   now_q, now_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   rvalid_q, rvalid_d;
  logic [IDX_W-1:0]       ridx_q, ridx_d;
  logic                   found_q, found_d;
  logic [IDX_W-1:0]       found_idx_q, found_idx_d;
  logic                   free_q, free_d;
  logic [IDX_W-1:0]       free_idx_q, free_idx_d;
  logic                   hit_q, hit_d;
  logic [VAL_W-1:0]       rval_q, rval_d;
  logic [COUNT_W-1:0]     removed_q, removed_d;
  out_beat_t              res_q, res_d;

  // entry layout: {valid, key, value, expiry}
  logic                   e_valid;
  logic [KEY_W-1:0]       e_key;
  logic [VAL_W-1:0]       e_value;
  logic [TIME_BITS-1:0]   e_expiry;
  logic                   key_eq;
  logic [TIME_BITS:0]     exp_sum;
  logic [TIME_BITS-1:0]   exp_sat;

  assign {e_valid, e_key, e_value, e_expiry} = mem_rdata_i;
  assign key_eq  = (e_key == item_q.key);
  assign exp_sum = {1'b0, now_q} + {{(TIME_BITS + 1 - DUR_W){1'b0}}, item_q.duration};
  assign exp_sat = exp_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : exp_sum[TIME_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      now_q    <= '0;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      cnt_q    <= cnt_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    ridx_q      <= ridx_d;
    found_q     <= found_d;
    found_idx_q <= found_idx_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    hit_q       <= hit_d;
    rval_q      <= rval_d;
    removed_q   <= removed_d;
    res_q       <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    now_d       = now_q;
    cnt_d       = cnt_q;
    rvalid_d    = 1'b0;
    ridx_d      = ridx_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    hit_d       = hit_q;
    rval_d      = rval_q;
    removed_d   = removed_q;
    res_d       = res_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = ridx_q;
    mem_wdata_o = {1'b0, e_key, e_value, e_expiry};
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[IDX_W-1:0];

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q[IDX_W-1:0];
        mem_wdata_o = '0;
        if (cnt_q[IDX_W-1:0] == IDX_LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d    = in_beat_i;
          cnt_d     = '0;
          found_d   = 1'b0;
          free_d    = 1'b0;
          hit_d     = 1'b0;
          rval_d    = MISS_VALUE;
          removed_d = '0;
          if (in_beat_i.kind == KIND_TICK) begin
            if (now_q != {TIME_BITS{1'b1}}) begin
              now_d = now_q + 1'b1;
            end
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (cnt_q != CNT_END) begin
          mem_re_o = 1'b1;
          rvalid_d = 1'b1;
          ridx_d   = cnt_q[IDX_W-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
        if (rvalid_q) begin
          case (item_q.kind)
            KIND_INSERT: begin
              if (e_valid && key_eq && !found_q) begin
                found_d     = 1'b1;
                found_idx_d = ridx_q;
              end
              if (!e_valid && !free_q) begin
                free_d     = 1'b1;
                free_idx_d = ridx_q;
              end
            end
            KIND_LOOKUP: begin
              if (e_valid && key_eq && !found_q) begin
                found_d = 1'b1;
                if (e_expiry >= now_q) begin
                  hit_d  = 1'b1;
                  rval_d = e_value;
                end
              end
            end
            KIND_CLEANUP: begin
              if (e_valid && (e_expiry < now_q)) begin
                mem_we_o = 1'b1;
                if (removed_q != COUNT_MAX) begin
                  removed_d = removed_q + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          if (ridx_q == IDX_LAST) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        res_d = '0;
        case (item_q.kind)
          KIND_INSERT: begin
            if (found_q || free_q) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = found_q ? found_idx_q : free_idx_q;
              mem_wdata_o = {1'b1, item_q.key, item_q.value, exp_sat};
            end else begin
              res_d.status = 1'b1;
            end
          end
          KIND_LOOKUP: begin
            res_d.hit          = hit_q;
            res_d.result_value = rval_q;
          end
          KIND_CLEANUP: begin
            res_d.removed_count = removed_q;
          end
          default: begin
          end
        endcase
        state_d = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_beat_o = res_q;

endmodule

FILE: rtl/ttl_key_value_table_core.sv
// Top level: TTL key/value table with entry memory, sequencer and output register.
`timescale 1ns / 1ps
// A table of ENTRIES key/value slots, each with an expiry time in ticks, all held in one
// single-port-read, single-port-write memory. After reset a clearing pass invalidates
// every slot; no beat is accepted until it ends. A tick beat skips the scan.
// Insert, lookup and cleanup scan every slot at one memory read per cycle; cleanup writes
// back freed slots during the scan, insert writes its slot once the scan ends. One beat is
// in flight at a time; the output register lets the next beat in while a result waits to
// be taken.
module ttl_key_value_table_core #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ttl_kv_pkg::in_beat_t  in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ttl_kv_pkg::out_beat_t out_beat_o
);
  import ttl_kv_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ENT_W = 1 + KEY_W + VAL_W + TIME_BITS;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;

  logic              res_valid;
  logic              res_take;
  out_beat_t         res_beat;

  logic              out_valid_q;
  out_beat_t         out_beat_q;

  ttl_kv_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ttl_kv_ctrl #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W),
    .ENT_W     (ENT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_take),
    .res_beat_o  (res_beat),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_beat_q <= res_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a beat while another is in flight");

  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_take) |=> (res_valid && $stable(res_beat)))
    else $error("pending result dropped or changed");

  a_no_mem_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("memory read and write to the same entry");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |-> !(res_beat.hit && res_beat.status))
    else $error("hit and full reported together");

endmodule
